>>> src/assert_macros.svh
// Assertion macros used by the RTL (dct2d_forward_block).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/dct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_pkg
// Constants, types and cosine tables for the 8x8 forward DCT block.
// ----------------------------------------------------------------------------
package dct_pkg;

    localparam int BLOCK_SIZE = 8;
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 6;
    localparam int STORE_DEPTH = 64;
    localparam int ROW_W      = 28;   // row-pass partial sum
    localparam int SUM_W      = 46;   // full 2-D sum, Q30
    localparam int PROD_W     = 64;   // normalized sum, Q45
    localparam int OPB_W      = 48;   // serial operand register
    localparam int DIG_W      = 4;
    localparam int CNT_W      = 4;
    localparam int COS_W      = 17;
    localparam int RND_SHIFT  = 44;   // divide by N * 2^41 with N = 8

    localparam logic [CNT_W-1:0] PIX_DIGITS  = 4'd2;
    localparam logic [CNT_W-1:0] ROW_DIGITS  = 4'd7;
    localparam logic [CNT_W-1:0] SUM_DIGITS  = 4'd12;

    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    typedef struct packed {
        logic             start;
        logic             top_signed;
        logic [CNT_W-1:0] digits;
    } t_mac_req;

    // cos(k*pi/16) in Q15, k = 0..8
    function automatic logic [15:0] cos_quadrant(input logic [3:0] idx);
        logic [15:0] val;
        case (idx)
            4'd0:    val = 16'd32768;
            4'd1:    val = 16'd32138;
            4'd2:    val = 16'd30274;
            4'd3:    val = 16'd27246;
            4'd4:    val = 16'd23170;
            4'd5:    val = 16'd18205;
            4'd6:    val = 16'd12540;
            4'd7:    val = 16'd6393;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

    // cos(k*pi/16) in Q15 for any k modulo 32
    function automatic logic signed [COS_W-1:0] cos_q15(input logic [4:0] k);
        logic [15:0] mag;
        logic        neg;
        mag = 16'd0;
        neg = 1'b0;
        if (k <= 5'd8) begin
            mag = cos_quadrant(k[3:0]);
        end else if (k <= 5'd16) begin
            mag = cos_quadrant(4'(5'd16 - k));
            neg = 1'b1;
        end else if (k <= 5'd24) begin
            mag = cos_quadrant(4'(k - 5'd16));
            neg = 1'b1;
        end else begin
            mag = cos_quadrant(4'(6'd32 - 6'(k)));
        end
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // C(u)*C(v) in Q15
    function automatic logic signed [COS_W-1:0] norm_q15(input logic [IDX_W-1:0] u,
                                                         input logic [IDX_W-1:0] v);
        logic signed [COS_W-1:0] val;
        if (u == '0 && v == '0) begin
            val = 17'sd16384;
        end else if (u == '0 || v == '0) begin
            val = 17'sd23170;
        end else begin
            val = 17'sd32768;
        end
        return val;
    endfunction

endpackage

>>> src/dct_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_pix_if / dct_coef_if
// Valid/ready channels for pixels in and coefficients out.
// ----------------------------------------------------------------------------
interface dct_pix_if
    import dct_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface dct_coef_if
    import dct_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic [IDX_W-1:0]         freq_row;
    logic [IDX_W-1:0]         freq_col;
    logic                     block_end;

    modport source (output valid, output coefficient, output freq_row,
                    output freq_col, output block_end, input ready);
    modport sink   (input valid, input coefficient, input freq_row,
                    input freq_col, input block_end, output ready);
endinterface

>>> src/dct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/dct_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_mac
// Digit-serial multiplier: a 17-bit signed factor times an operand shifted
// in four bits per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module dct_mac
    import dct_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_req                 i_req,
    input  logic signed [COS_W-1:0]  i_a,
    input  logic [OPB_W-1:0]         i_b,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_prod
);
    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_sgn;
    logic                     r_first;
    logic signed [COS_W-1:0]  r_a;
    logic [OPB_W-1:0]         r_b;
    logic signed [PROD_W-1:0] r_p;

    logic                            dig_ext;
    logic signed [DIG_W:0]           dig;
    logic signed [COS_W+DIG_W:0]     pp;

    always_comb begin
        // top digit of a signed operand carries the sign
        dig_ext = r_first && r_sgn && r_b[OPB_W-1];
        dig     = $signed({dig_ext, r_b[OPB_W-1 -: DIG_W]});
        pp      = r_a * dig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_first <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a     <= i_a;
                r_b     <= i_b;
                r_cnt   <= i_req.digits;
                r_sgn   <= i_req.top_signed;
                r_first <= 1'b1;
                r_p     <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_p     <= (r_p <<< DIG_W) + PROD_W'(pp);
                r_b     <= r_b << DIG_W;
                r_cnt   <= r_cnt - CNT_W'(1);
                r_first <= 1'b0;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

>>> src/dct2d_forward_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct2d_forward_block
// 8x8 forward 2-D DCT-II, row-column, on one digit-serial multiplier.
// ----------------------------------------------------------------------------
// i_pix takes 64 unsigned pixels in row-major order, one per transfer, one
// per cycle while ready is high. After the 64th transfer ready drops and
// the block runs the row pass (64 partial sums, 8 terms each), then the column
// pass, sending each of the 64 coefficients on o_coef as it is done, in
// row-major order (u outer, v inner), signed Q12.3, block_end set on the last.
// Every product goes through one 17-bit by 4-bit-digit multiplier: pixel terms,
// column terms and the final scaling in turn. A new block is taken only after
// the last coefficient of the previous one has been sent.
// A stalled receiver holds the block in place; nothing is lost.
// Reset returns the block to loading with an empty count; the pixel and
// partial sum stores are not cleared.
// ----------------------------------------------------------------------------
module dct2d_forward_block
    import dct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dct_pix_if.sink           i_pix,
    dct_coef_if.source        o_coef
);
`include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_LOAD, S_ROW_RD, S_ROW_GO, S_ROW_WAIT,
        S_COL_RD, S_COL_GO, S_COL_WAIT, S_NORM, S_NORM_WAIT, S_OUT
    } t_state;

    t_state                   r_state, n_state;
    logic [ADDR_W-1:0]        r_cnt, n_cnt;
    logic [IDX_W-1:0]         r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic signed [COEF_W-1:0] r_coef, n_coef;
    logic [IDX_W-1:0]         r_frow, n_frow, r_fcol, n_fcol;
    logic                     r_bend, n_bend;

    logic                     pix_acc;
    logic [PIX_W-1:0]         pix_rdata;
    logic                     row_we;
    logic [ROW_W-1:0]         row_rdata;
    t_mac_req                 mac_req;
    logic signed [COS_W-1:0]  mac_a;
    logic [OPB_W-1:0]         mac_b;
    logic                     mac_done;
    logic signed [PROD_W-1:0] mac_prod;

    logic [6:0]               ang_row, ang_col;
    logic signed [SUM_W-1:0]  acc;
    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        rnd;
    logic [PROD_W-RND_SHIFT-1:0] q;
    logic signed [COEF_W-1:0] sat;

    assign pix_acc      = i_pix.valid && i_pix.ready;
    assign i_pix.ready  = (r_state == S_LOAD);
    assign o_coef.valid = (r_state == S_OUT);
    assign o_coef.coefficient = r_coef;
    assign o_coef.freq_row    = r_frow;
    assign o_coef.freq_col    = r_fcol;
    assign o_coef.block_end   = r_bend;

    dct_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_cnt),
        .i_wdata (i_pix.pixel_value),
        .i_raddr ({r_i, r_k}),
        .o_rdata (pix_rdata)
    );

    dct_ram #(.WIDTH(ROW_W), .DEPTH(STORE_DEPTH)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr ({r_i, r_j}),
        .i_wdata (acc[ROW_W-1:0]),
        .i_raddr ({r_k, r_j}),
        .o_rdata (row_rdata)
    );

    dct_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_prod  (mac_prod)
    );

    // operand select and rounding
    always_comb begin
        ang_row = 7'({r_k, 1'b1}) * 7'(r_j);
        ang_col = 7'({r_k, 1'b1}) * 7'(r_i);
        acc     = r_sum + mac_prod[SUM_W-1:0];

        mac_req = '0;
        mac_a   = cos_q15(ang_row[4:0]);
        mac_b   = {pix_rdata, (OPB_W-PIX_W)'(0)};
        case (r_state)
            S_ROW_GO: begin
                mac_req.start  = 1'b1;
                mac_req.digits = PIX_DIGITS;
            end
            S_COL_GO: begin
                mac_req.start      = 1'b1;
                mac_req.top_signed = 1'b1;
                mac_req.digits     = ROW_DIGITS;
                mac_a = cos_q15(ang_col[4:0]);
                mac_b = {row_rdata, (OPB_W-ROW_W)'(0)};
            end
            S_NORM: begin
                mac_req.start      = 1'b1;
                mac_req.top_signed = 1'b1;
                mac_req.digits     = SUM_DIGITS;
                mac_a = norm_q15(r_i, r_j);
                mac_b = OPB_W'(r_sum);
            end
            default: begin
            end
        endcase

        row_we = (r_state == S_ROW_WAIT) && mac_done && (r_k == IDX_LAST);

        // round half away from zero, then saturate
        neg = mac_prod[PROD_W-1];
        mag = neg ? PROD_W'(-mac_prod) : PROD_W'(mac_prod);
        rnd = mag + (PROD_W'(1) << (RND_SHIFT - 1));
        q   = rnd[PROD_W-1:RND_SHIFT];
        if (neg) begin
            sat = (q > (PROD_W-RND_SHIFT)'(32768)) ? -16'sd32768 : COEF_W'(-q);
        end else begin
            sat = (q > (PROD_W-RND_SHIFT)'(32767)) ? 16'sd32767 : COEF_W'(q);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_sum   = r_sum;
        n_coef  = r_coef;
        n_frow  = r_frow;
        n_fcol  = r_fcol;
        n_bend  = r_bend;
        case (r_state)
            S_LOAD: begin
                if (pix_acc) begin
                    n_cnt = r_cnt + ADDR_W'(1);
                    if (r_cnt == ADDR_W'(STORE_DEPTH - 1)) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_sum   = '0;
                        n_state = S_ROW_RD;
                    end
                end
            end
            S_ROW_RD: n_state = S_ROW_GO;
            S_ROW_GO: n_state = S_ROW_WAIT;
            S_ROW_WAIT: begin
                if (mac_done) begin
                    n_state = S_ROW_RD;
                    if (r_k == IDX_LAST) begin
                        n_sum = '0;
                        n_k   = '0;
                        n_j   = r_j + IDX_W'(1);
                        if (r_j == IDX_LAST) begin
                            n_i = r_i + IDX_W'(1);
                            if (r_i == IDX_LAST) begin
                                n_state = S_COL_RD;
                            end
                        end
                    end else begin
                        n_sum = acc;
                        n_k   = r_k + IDX_W'(1);
                    end
                end
            end
            S_COL_RD: n_state = S_COL_GO;
            S_COL_GO: n_state = S_COL_WAIT;
            S_COL_WAIT: begin
                if (mac_done) begin
                    n_sum = acc;
                    if (r_k == IDX_LAST) begin
                        n_state = S_NORM;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_COL_RD;
                    end
                end
            end
            S_NORM: n_state = S_NORM_WAIT;
            S_NORM_WAIT: begin
                if (mac_done) begin
                    n_coef  = sat;
                    n_frow  = r_i;
                    n_fcol  = r_j;
                    n_bend  = (r_i == IDX_LAST) && (r_j == IDX_LAST);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_coef.ready) begin
                    n_k   = '0;
                    n_sum = '0;
                    n_j   = r_j + IDX_W'(1);
                    if (r_j == IDX_LAST) begin
                        n_i = r_i + IDX_W'(1);
                    end
                    n_state = r_bend ? S_LOAD : S_COL_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
        r_sum  <= n_sum;
        r_coef <= n_coef;
        r_frow <= n_frow;
        r_fcol <= n_fcol;
        r_bend <= n_bend;
    end

    `ASSERT_NOW(a_in_out_excl, i_clk, i_rst_n, o_coef.valid, !i_pix.ready)
    `ASSERT_NOW(a_end_last, i_clk, i_rst_n, o_coef.valid && o_coef.block_end, (o_coef.freq_row == IDX_LAST) && (o_coef.freq_col == IDX_LAST))
    `ASSERT_NOW(a_done_wait, i_clk, i_rst_n, mac_done, (r_state == S_ROW_WAIT) || (r_state == S_COL_WAIT) || (r_state == S_NORM_WAIT))
    `ASSERT_NEXT(a_full_stop, i_clk, i_rst_n, pix_acc && (r_cnt == ADDR_W'(STORE_DEPTH - 1)), !i_pix.ready)
endmodule

>>> tb/dct_coef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_coef_checker
// Watches the pixel and coefficient channels of the 8x8 forward DCT block.
// Keeps its own copy of the pixel block, computes the 64 coefficients when
// the last pixel of a block is taken, and compares every coefficient transfer
// field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module dct_coef_checker
    import dct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dct_pix_if   i_pix,
    dct_coef_if  i_coef,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_coef_count,
    output int   o_block_count
);

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [IDX_W-1:0]         freq_row;
        logic [IDX_W-1:0]         freq_col;
        logic                     block_end;
    } t_coef;

    // cos(k*pi/16) in Q15, first quadrant
    localparam int COS_QUAD[0:8] = '{32768, 32138, 30274, 27246, 23170,
                                     18205, 12540, 6393, 0};

    logic [PIX_W-1:0] block_pixels[STORE_DEPTH];
    int               pixels_held;
    t_coef            expected_coefs[$];

    function automatic longint cosine_q15(input int k);
        int r;
        r = k % 32;
        if (r <= 8)  return  COS_QUAD[r];
        if (r <= 16) return -COS_QUAD[16 - r];
        if (r <= 24) return -COS_QUAD[r - 16];
        return COS_QUAD[32 - r];
    endfunction

    // Direct 2-D sum, normalized, rounded half away from zero, saturated.
    function automatic logic signed [COEF_W-1:0] dct_coefficient(input int u, input int v);
        longint sum;
        longint norm;
        longint scaled;
        longint mag;
        longint q;
        sum = 0;
        for (int x = 0; x < BLOCK_SIZE; x++) begin
            for (int y = 0; y < BLOCK_SIZE; y++) begin
                sum += longint'(block_pixels[x*BLOCK_SIZE + y])
                       * cosine_q15((2*x + 1) * u) * cosine_q15((2*y + 1) * v);
            end
        end
        if (u == 0 && v == 0) begin
            norm = 16384;
        end else if (u == 0 || v == 0) begin
            norm = 23170;
        end else begin
            norm = 32768;
        end
        scaled = sum * norm;
        mag = (scaled < 0) ? -scaled : scaled;
        q = (mag + (longint'(1) << 43)) >>> 44;
        if (scaled < 0) begin
            return (q > 32768) ? -16'sd32768 : COEF_W'(-q);
        end
        return (q > 32767) ? 16'sd32767 : COEF_W'(q);
    endfunction

    always @(posedge i_clk) begin
        t_coef exp_c;
        if (!i_rst_n) begin
            pixels_held <= 0;
            o_fail_count <= 0;
            o_coef_count <= 0;
            o_block_count <= 0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                block_pixels[pixels_held] = i_pix.pixel_value;
                if (pixels_held == STORE_DEPTH - 1) begin
                    for (int u = 0; u < BLOCK_SIZE; u++) begin
                        for (int v = 0; v < BLOCK_SIZE; v++) begin
                            exp_c.coefficient = dct_coefficient(u, v);
                            exp_c.freq_row    = IDX_W'(u);
                            exp_c.freq_col    = IDX_W'(v);
                            exp_c.block_end   = (u == BLOCK_SIZE-1 && v == BLOCK_SIZE-1);
                            expected_coefs.push_back(exp_c);
                        end
                    end
                    pixels_held <= 0;
                    o_block_count <= o_block_count + 1;
                end else begin
                    pixels_held <= pixels_held + 1;
                end
            end
            if (i_coef.valid && i_coef.ready) begin
                o_coef_count <= o_coef_count + 1;
                if (expected_coefs.size() == 0) begin
                    $error("coefficient transfer with nothing outstanding: %0d",
                           i_coef.coefficient);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_c = expected_coefs.pop_front();
                    if (i_coef.coefficient !== exp_c.coefficient ||
                        i_coef.freq_row !== exp_c.freq_row ||
                        i_coef.freq_col !== exp_c.freq_col ||
                        i_coef.block_end !== exp_c.block_end) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (i_coef.coefficient !== exp_c.coefficient)
                        $error("coefficient: expected %0d, got %0d",
                               exp_c.coefficient, i_coef.coefficient);
                    if (i_coef.freq_row !== exp_c.freq_row)
                        $error("freq_row: expected %0d, got %0d",
                               exp_c.freq_row, i_coef.freq_row);
                    if (i_coef.freq_col !== exp_c.freq_col)
                        $error("freq_col: expected %0d, got %0d",
                               exp_c.freq_col, i_coef.freq_col);
                    if (i_coef.block_end !== exp_c.block_end)
                        $error("block_end: expected %0d, got %0d",
                               exp_c.block_end, i_coef.block_end);
                end
            end
        end
        o_pending <= expected_coefs.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds pixel blocks to the 8x8 forward DCT in random bursts while the
// coefficient side stalls on its own pattern, including one long hold-off
// that backs up the block. Checking is done in dct_coef_checker.
// ----------------------------------------------------------------------------
module testbench;
    import dct_pkg::*;

    localparam int NUM_BLOCKS = 5;
    localparam int HOLD_CYCLES = 3000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   coef_count;
    int   block_count;
    logic hold_off;
    logic hold_done;
    int   recv_cycle;

    dct_pix_if  pix();
    dct_coef_if coef();

    dct2d_forward_block dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_coef  (coef)
    );

    dct_coef_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix),
        .i_coef        (coef),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_coef_count  (coef_count),
        .o_block_count (block_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: stall pattern steps through four modes in turn.
    always @(posedge i_clk) begin
        logic pat;
        if (!i_rst_n) begin
            recv_cycle <= 0;
            coef.ready <= 1'b0;
        end else begin
            case ((recv_cycle / 400) % 4)
                0:       pat = 1'b1;
                1:       pat = ($urandom_range(0, 1) == 1);
                2:       pat = ($urandom_range(0, 7) != 0);
                default: pat = ((recv_cycle % 24) >= 16);
            endcase
            recv_cycle <= recv_cycle + 1;
            coef.ready <= pat && !hold_off;
        end
    end

    // Long hold-off once the first coefficient shows up.
    initial begin
        hold_off = 1'b0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!(coef.valid && i_rst_n)) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
        hold_done <= 1'b1;
    end

    int burst_left;

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        pix.valid <= 1'b1;
        pix.pixel_value <= value;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        burst_left--;
    endtask

    initial begin
        logic [PIX_W-1:0] directed[25];
        int mode;
        int wait_cycles;
        directed = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'h55, 8'hAA, 8'h0F,
                     8'hF0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                     8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        burst_left = 0;
        i_rst_n = 1'b0;
        pix.valid = 1'b0;
        pix.pixel_value = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First block opens with extremes and bit patterns, then random fill.
        for (int i = 0; i < STORE_DEPTH; i++) begin
            send_pixel(i < 25 ? directed[i] : PIX_W'($urandom_range(0, 255)));
        end
        // Full-scale flat block, checkerboard (highest frequencies), then blocks of a randomly chosen kind.
        for (int b = 1; b < NUM_BLOCKS; b++) begin
            mode = (b < 3) ? b : $urandom_range(0, 3);
            for (int i = 0; i < STORE_DEPTH; i++) begin
                case (mode)
                    1:       send_pixel(8'd255);
                    2:       send_pixel((((i / 8) + (i % 8)) & 1) ? 8'd255 : 8'd0);
                    3:       send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
                    default: send_pixel(PIX_W'($urandom_range(0, 255)));
                endcase
            end
        end
        pix.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0 || !hold_done) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 3000) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("Sent %0d pixel blocks (extremes, flat, checkerboard, random).",
                 block_count);
        $display("Checked %0d coefficients under random stalls and a long hold-off.",
                 coef_count);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/dct_pkg.sv
src/dct_stream_if.sv
src/dct_ram.sv
src/dct_mac.sv
src/dct2d_forward_block.sv
tb/dct_coef_checker.sv
tb/testbench.sv
